/* hdl/wots_message_digits_checksum_defines.svh */
`ifndef WOTS_MESSAGE_DIGITS_CHECKSUM_DEFINES_SVH
`define WOTS_MESSAGE_DIGITS_CHECKSUM_DEFINES_SVH

`ifndef SYNTH
`define WMDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmdc check failed");
`define WMDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmdc check failed");
`else
`define WMDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WMDC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/wmdc_pkg.sv */
package wmdc_pkg;

    localparam int DIGEST_BYTES    = 32;
    localparam int LOG_W           = 4;
    localparam int CHECKSUM_DIGITS = 3;

    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int INDEX_W  = 7;
    localparam int CSUM_W   = 10;

    localparam int PER_BYTE     = BYTE_W / LOG_W;
    localparam int MSG_DIGITS   = DIGEST_BYTES * PER_BYTE;
    localparam int TOTAL_DIGITS = MSG_DIGITS + CHECKSUM_DIGITS;
    localparam int CSV_W        = CHECKSUM_DIGITS * LOG_W;
    localparam int IDX_W        = $clog2(TOTAL_DIGITS);
    localparam int STEP_W       = $clog2(PER_BYTE + CHECKSUM_DIGITS);
    localparam int BS_W         = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef logic [LOG_W-1:0] t_wdigit;

    typedef struct packed {
        logic [BYTE_W-1:0] digest_byte;
        logic              final_byte;
    } t_entry;

endpackage

/* hdl/wmdc_if.sv */
interface wmdc_byte_if import wmdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] digest_byte;

    modport source (output valid, output digest_byte, input ready);
    modport sink   (input valid, input digest_byte, output ready);
endinterface

interface wmdc_digit_if import wmdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic [INDEX_W-1:0] digit_index;
    logic               is_checksum;
    logic               last;

    modport source (output valid, output digit, output digit_index, output is_checksum,
                    output last, input ready);
    modport sink   (input valid, input digit, input digit_index, input is_checksum,
                    input last, output ready);
endinterface

/* hdl/wmdc_front.sv */
module wmdc_front import wmdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_digest_byte,
    output logic              o_push,
    input  logic              i_push_ready,
    output t_entry            o_entry
);

    logic [BS_W-1:0] r_bytes;
    logic [BS_W-1:0] n_bytes;
    logic            is_final;

    assign is_final = (r_bytes == BS_W'(DIGEST_BYTES - 1));
    assign o_ready  = i_push_ready;
    assign o_push   = i_valid;

    assign o_entry.digest_byte = i_digest_byte;
    assign o_entry.final_byte  = is_final;

    always_comb begin
        n_bytes = r_bytes;
        if (i_valid && i_push_ready) begin
            n_bytes = is_final ? '0 : r_bytes + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
        end else begin
            r_bytes <= n_bytes;
        end
    end

endmodule

/* hdl/wmdc_queue.sv */
module wmdc_queue import wmdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_push_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_pop_ready,
    output t_entry o_entry
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr;
    logic              rd;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_entry      = r_mem[r_rp];
    assign wr           = i_push && o_push_ready;
    assign rd           = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/wmdc_back.sv */
module wmdc_back import wmdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_entry,
    wmdc_digit_if.source o_digit
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MSG  = 3'b010,
        S_CSUM = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [BYTE_W-1:0]  r_work, n_work;
    logic               r_final, n_final;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [CSUM_W-1:0]  r_csum, n_csum;
    logic [CSV_W-1:0]   r_csv, n_csv;
    logic [IDX_W-1:0]   r_idx, n_idx;

    logic               r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0] r_out_digit;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_csum;
    logic               r_out_last;

    logic    emit;
    logic    last_step;
    logic    last_msg_step;
    logic    pop_ok;
    t_wdigit d_msg;
    t_wdigit d_csum;
    t_wdigit d_cur;
    logic    cur_csum;

    assign d_msg         = r_work[BYTE_W-1 -: LOG_W];
    assign d_csum        = r_csv[CSV_W-1 -: LOG_W];
    assign cur_csum      = (r_state == S_CSUM);
    assign d_cur         = cur_csum ? d_csum : d_msg;
    assign last_msg_step = (r_step == STEP_W'(PER_BYTE - 1));
    assign emit          = (r_state != S_IDLE) && (!r_out_valid || o_digit.ready);
    assign last_step     = cur_csum ? (r_step == STEP_W'(PER_BYTE + CHECKSUM_DIGITS - 1))
                                    : (last_msg_step && !r_final);
    assign pop_ok        = (r_state == S_IDLE) || (emit && last_step);
    assign o_ready       = pop_ok;

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_final     = r_final;
        n_step      = r_step;
        n_csum      = r_csum;
        n_csv       = r_csv;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (o_digit.ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_idx       = (cur_csum && last_step) ? '0 : r_idx + 1'b1;
            n_step      = r_step + 1'b1;
            unique case (r_state)
                S_MSG: begin
                    n_csum = r_csum + CSUM_W'(~d_msg);
                    n_csv  = CSV_W'(n_csum);
                    n_work = r_work << LOG_W;
                    if (last_msg_step) begin
                        if (r_final) begin
                            n_state = S_CSUM;
                            n_csum  = '0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
                S_CSUM: begin
                    n_csv = r_csv << LOG_W;
                    if (last_step) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
        if (pop_ok && i_valid) begin
            n_state = S_MSG;
            n_work  = i_entry.digest_byte;
            n_final = i_entry.final_byte;
            n_step  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_csum      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_csum      <= n_csum;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_final <= n_final;
        r_csv   <= n_csv;
        if (emit) begin
            r_out_digit <= DIGIT_W'(d_cur);
            r_out_index <= INDEX_W'(r_idx);
            r_out_csum  <= cur_csum;
            r_out_last  <= cur_csum && last_step;
        end
    end

    assign o_digit.valid       = r_out_valid;
    assign o_digit.digit       = r_out_digit;
    assign o_digit.digit_index = r_out_index;
    assign o_digit.is_checksum = r_out_csum;
    assign o_digit.last        = r_out_last;

endmodule

/* hdl/wots_message_digits_checksum.sv */
// channel    | dir | payload                                  | handshake
// -----------+-----+------------------------------------------+------------
// i_byte     | in  | digest_byte[7:0]                         | valid/ready
// o_digit    | out | digit[3:0] digit_index[6:0] is_checksum last | valid/ready
//
// each digest byte yields two digits at one digit per cycle while the output is not stalled,
// set by the single digit output register of the back end
// the final byte of a message adds three checksum digits
// a 2-entry queue between front and back accepts input while output stalls, until full
// synchronous active-low reset clears the byte counter, checksum, queue and output valid
`include "wots_message_digits_checksum_defines.svh"

module wots_message_digits_checksum import wmdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wmdc_byte_if.sink    i_byte,
    wmdc_digit_if.source o_digit
);

    logic   f_push;
    logic   f_push_ready;
    t_entry f_entry;
    logic   q_valid;
    logic   q_ready;
    t_entry q_entry;

    wmdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_byte.valid),
        .o_ready      (i_byte.ready),
        .i_digest_byte(i_byte.digest_byte),
        .o_push       (f_push),
        .i_push_ready (f_push_ready),
        .o_entry      (f_entry)
    );

    wmdc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .o_push_ready(f_push_ready),
        .i_entry     (f_entry),
        .o_valid     (q_valid),
        .i_pop_ready (q_ready),
        .o_entry     (q_entry)
    );

    wmdc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_entry(q_entry),
        .o_digit(o_digit)
    );

    `WMDC_ASSERT_IMP(a_last_is_csum, i_clk, i_rst_n, o_digit.valid && o_digit.last, o_digit.is_checksum)
    `WMDC_ASSERT_IMP(a_last_index, i_clk, i_rst_n, o_digit.valid && o_digit.last, o_digit.digit_index == INDEX_W'(TOTAL_DIGITS - 1))
    `WMDC_ASSERT_NXT(a_accept_queued, i_clk, i_rst_n, i_byte.valid && i_byte.ready, q_valid)

endmodule

/* tb/sv/wots_message_digits_checksum_tb.sv */
`timescale 1ns / 1ps

module wots_message_digits_checksum_tb;
    import wmdc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 455;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_TRIGGER = 150;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [INDEX_W-1:0] digit_index;
        logic               is_checksum;
        logic               last;
    } t_digit_rec;

    typedef enum int {MSG_RANDOM, MSG_ZEROS, MSG_ONES, MSG_NIBBLE_EXT} t_msg_mode;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    class digit_scoreboard;
        t_digit_rec        expected_q[$];
        int                bytes_in_msg;
        logic [CSUM_W-1:0] csum = '0;
        int                errors;
        int                checked;
        int                messages;

        function void note_byte(logic [BYTE_W-1:0] db);
            int mask;
            int shift;
            int d;
            t_digit_rec rec;
            mask = (1 << LOG_W) - 1;
            for (int j = 0; j < PER_BYTE; j++) begin
                shift = BYTE_W - (j + 1) * LOG_W;
                d = (int'(db) >> shift) & mask;
                csum = CSUM_W'(int'(csum) + (mask - d));
                rec.digit = DIGIT_W'(d);
                rec.digit_index = INDEX_W'(bytes_in_msg * PER_BYTE + j);
                rec.is_checksum = 1'b0;
                rec.last = 1'b0;
                expected_q.push_back(rec);
            end
            bytes_in_msg++;
            if (bytes_in_msg >= DIGEST_BYTES) begin
                for (int k = 0; k < CHECKSUM_DIGITS; k++) begin
                    shift = (CHECKSUM_DIGITS - 1 - k) * LOG_W;
                    d = (shift < 32) ? ((int'(csum) >> shift) & mask) : 0;
                    rec.digit = DIGIT_W'(d);
                    rec.digit_index = INDEX_W'(MSG_DIGITS + k);
                    rec.is_checksum = 1'b1;
                    rec.last = (k + 1 == CHECKSUM_DIGITS);
                    expected_q.push_back(rec);
                end
                bytes_in_msg = 0;
                csum = '0;
            end
        endfunction

        function bit field_ok(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_val, act_val);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_digit(t_digit_rec act);
            t_digit_rec exp_rec;
            bit ok;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected digit transaction expected none actual %0h",
                         $realtime, act);
                errors++;
                return;
            end
            exp_rec = expected_q.pop_front();
            checked++;
            ok = field_ok("digit", int'(exp_rec.digit), int'(act.digit));
            ok &= field_ok("digit_index", int'(exp_rec.digit_index), int'(act.digit_index));
            ok &= field_ok("is_checksum", int'(exp_rec.is_checksum), int'(act.is_checksum));
            ok &= field_ok("last", int'(exp_rec.last), int'(act.last));
            if (!ok) errors++;
            if (act.last) messages++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    wmdc_byte_if  byte_ch();
    wmdc_digit_if digit_ch();

    wots_message_digits_checksum uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_digit (digit_ch)
    );

    digit_scoreboard sb = new();

    int cycles;
    int in_stall_cycles;
    int hold_left;
    int hold_peak;
    bit hold_done;
    int bytes_sent;
    t_rx_mode rx_mode;
    int rx_mode_left;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.digest_byte = '0;
        digit_ch.ready = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digits outstanding", $realtime, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output monitor, which also counts input stall cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_ch.valid && !byte_ch.ready) in_stall_cycles++;
            if (digit_ch.valid && digit_ch.ready)
                sb.check_digit({digit_ch.digit, digit_ch.digit_index,
                                digit_ch.is_checksum, digit_ch.last});
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(negedge i_clk) begin
        if (!hold_done && sb.checked >= HOLD_TRIGGER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 120);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            digit_ch.ready = 1'b0;
            hold_left--;
            hold_peak++;
        end else begin
            case (rx_mode)
                RX_OPEN:   digit_ch.ready = 1'b1;
                RX_COIN:   digit_ch.ready = ($urandom_range(0, 1) == 1);
                RX_SPARSE: digit_ch.ready = ($urandom_range(0, 3) == 0);
                default:   digit_ch.ready = ~digit_ch.ready;
            endcase
        end
    end

    task automatic drive_byte(input logic [BYTE_W-1:0] db);
        @(negedge i_clk);
        byte_ch.valid = 1'b1;
        byte_ch.digest_byte = db;
        do @(posedge i_clk); while (!byte_ch.ready);
        sb.note_byte(db);
        bytes_sent++;
    endtask

    task automatic idle_gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            byte_ch.valid = 1'b0;
            byte_ch.digest_byte = BYTE_W'($urandom_range(0, 255));
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(t_msg_mode mode);
        case (mode)
            MSG_ZEROS:      return 8'h00;
            MSG_ONES:       return 8'hFF;
            MSG_NIBBLE_EXT: return {($urandom_range(0, 1) ? 4'hF : 4'h0),
                                    ($urandom_range(0, 1) ? 4'hF : 4'h0)};
            default:        return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [BYTE_W-1:0] directed[25];
        int msg_pos;
        int msg_idx;
        int burst;
        int sent;
        t_msg_mode mode;

        directed = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h10, 8'h80, 8'h08, 8'h7F,
                     8'hF7, 8'hFE, 8'hEF, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h12, 8'h34,
                     8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF1, 8'h69};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) drive_byte(directed[i]);
        msg_pos = 25;
        msg_idx = 0;
        mode = MSG_RANDOM;
        sent = 0;

        // first full messages hit the checksum extremes, then a mix
        while (sent < RANDOM_BYTES || msg_pos != 0) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst; i++) begin
                if (msg_pos == 0) begin
                    if (msg_idx == 1) mode = MSG_ZEROS;
                    else if (msg_idx == 2) mode = MSG_ONES;
                    else case ($urandom_range(0, 5))
                        3:       mode = MSG_ZEROS;
                        4:       mode = MSG_ONES;
                        5:       mode = MSG_NIBBLE_EXT;
                        default: mode = MSG_RANDOM;
                    endcase
                end
                drive_byte(pick_byte(mode));
                sent++;
                msg_pos++;
                if (msg_pos == DIGEST_BYTES) begin
                    msg_pos = 0;
                    msg_idx++;
                end
                if (sent >= RANDOM_BYTES && msg_pos == 0) break;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
        idle_gap(1);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d digits never arrived", $realtime, sb.pending());
            sb.errors++;
        end

        $display("run: %0d digest bytes, %0d complete messages, %0d digits checked",
                 bytes_sent, sb.messages, sb.checked);
        $display("run: output hold-off of %0d cycles, input back-pressured for %0d cycles",
                 hold_peak, in_stall_cycles);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
